[hdl/wtmf_pkg.sv]
// Shared constants and command type for the window trimmed mean filter.
`timescale 1ns / 1ps
`default_nettype none

package wtmf_pkg;

    localparam int DIST_W       = 16;
    localparam int CH_W         = 2;
    localparam int Q_W          = 16;
    localparam int WINDOW_DEF   = 8;
    localparam int KEEP_DEF     = 4;
    localparam int TRIM_DEF     = 2;
    localparam int CHANNELS_DEF = 4;

    typedef struct packed {
        logic load;
        logic write;
        logic sort_init;
        logic rd_en;
        logic acc_clr;
        logic acc_en;
        logic div_en;
        logic out_load;
    } dp_cmd_t;

endpackage

`default_nettype wire

[hdl/window_trimmed_mean_filter_top.sv]
// Top level of the per-channel sliding window trimmed mean filter.
// Per item: load, write to the channel's window, scan the window one read per cycle into
// the sorter, sum the kept ranks in KEEP steps, divide, register; an out-of-range channel
// skips to the output. One item at a time; a result waits while the next item is taken.
// Reset (rst_n, async active low) clears control state and every window's fill count,
// so all windows read as zero; the window memory itself is not swept.
`timescale 1ns / 1ps
`default_nettype none

module window_trimmed_mean_filter_top #(
    parameter int WINDOW   = wtmf_pkg::WINDOW_DEF,
    parameter int KEEP     = wtmf_pkg::KEEP_DEF,
    parameter int TRIM     = wtmf_pkg::TRIM_DEF,
    parameter int CHANNELS = wtmf_pkg::CHANNELS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [15:0]                  s_tdata,   // [15:0] distance
    input  wire logic [wtmf_pkg::CH_W-1:0]    s_tuser,   // [1:0] channel
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [15:0]                       m_tdata,   // [15:0] filtered_distance
    output logic [wtmf_pkg::CH_W-1:0]         m_tuser    // [1:0] out_channel
);

    localparam int MAX_WK = (WINDOW > KEEP) ? WINDOW : KEEP;
    localparam int CNT_W  = $clog2(MAX_WK);

    wtmf_pkg::dp_cmd_t cmd;
    logic [CNT_W-1:0]  idx;
    logic              in_range;

    wtmf_ctrl #(
        .WINDOW (WINDOW),
        .KEEP   (KEEP),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .in_range  (in_range),
        .cmd       (cmd),
        .idx       (idx)
    );

    wtmf_dp #(
        .WINDOW   (WINDOW),
        .KEEP     (KEEP),
        .TRIM     (TRIM),
        .CHANNELS (CHANNELS),
        .CNT_W    (CNT_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .idx          (idx),
        .in_channel   (s_tuser),
        .in_distance  (s_tdata),
        .in_range     (in_range),
        .out_channel  (m_tuser),
        .out_distance (m_tdata)
    );

endmodule

`default_nettype wire

[hdl/wtmf_ctrl.sv]
// Sequencing state machine and output valid register of the filter.
`timescale 1ns / 1ps
`default_nettype none

module wtmf_ctrl #(
    parameter int WINDOW = wtmf_pkg::WINDOW_DEF,
    parameter int KEEP   = wtmf_pkg::KEEP_DEF,
    parameter int CNT_W  = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire logic             in_range,
    output wtmf_pkg::dp_cmd_t     cmd,
    output logic [CNT_W-1:0]      idx
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = in_range ? S_WRITE : S_DONE;
                end
            end
            S_WRITE:
            begin
                cmd.write     = 1'b1;
                cmd.sort_init = 1'b1;
                state_next    = S_READ;
            end
            S_READ:
            begin
                cmd.rd_en = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WINDOW - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.acc_clr = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.acc_en = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(KEEP - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_en = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign idx       = cnt_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[hdl/wtmf_dp.sv]
// Datapath: window memory, insertion sorter, rank accumulator and divider.
`timescale 1ns / 1ps
`default_nettype none

module wtmf_dp #(
    parameter int WINDOW   = wtmf_pkg::WINDOW_DEF,
    parameter int KEEP     = wtmf_pkg::KEEP_DEF,
    parameter int TRIM     = wtmf_pkg::TRIM_DEF,
    parameter int CHANNELS = wtmf_pkg::CHANNELS_DEF,
    parameter int CNT_W    = 3
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wtmf_pkg::dp_cmd_t             cmd,
    input  wire logic [CNT_W-1:0]              idx,
    input  wire logic [wtmf_pkg::CH_W-1:0]     in_channel,
    input  wire logic [wtmf_pkg::DIST_W-1:0]   in_distance,
    output logic                               in_range,
    output logic [wtmf_pkg::CH_W-1:0]          out_channel,
    output logic [wtmf_pkg::DIST_W-1:0]        out_distance
);

    localparam int DW    = wtmf_pkg::DIST_W;
    localparam int QW    = wtmf_pkg::Q_W;
    localparam int IW    = $clog2(WINDOW);
    localparam int FW    = $clog2(WINDOW + 1);
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * (2 ** IW);
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(KEEP);
    localparam int SUM_W = DW + KW;
    localparam int BASE  = WINDOW / 2 - TRIM;
    localparam int SH    = SUM_W + KW;
    localparam int MW    = SUM_W + 1;
    localparam int PW    = SUM_W + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((longint'(1) << SH) + longint'(KEEP) - 1) / longint'(KEEP));

    logic [wtmf_pkg::CH_W-1:0] ch_reg;
    logic [DW-1:0]             smp_reg;
    logic [FW-1:0]             fill_reg [CHANNELS];
    logic [IW-1:0]             ptr_reg  [CHANNELS];
    logic [FW-1:0]             cur_fill_reg;
    logic [DW-1:0]             mem [DEPTH];
    logic [DW-1:0]             mem_q_reg;
    logic                      rd_valid_reg;
    logic [IW-1:0]             rd_idx_reg;
    logic [DW-1:0]             sort_reg  [WINDOW];
    logic [DW-1:0]             sort_next [WINDOW];
    logic [SUM_W-1:0]          acc_reg;
    logic [QW-1:0]             q_reg;
    logic [wtmf_pkg::CH_W-1:0] out_ch_reg;
    logic [DW-1:0]             out_dist_reg;

    logic [CW-1:0]             row;
    logic [FW-1:0]             fill_cur;
    logic [FW-1:0]             fill_wr;
    logic [IW-1:0]             ptr_cur;
    logic [IW-1:0]             ptr_wr;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;
    logic [DW-1:0]             ins_val;
    logic [IW-1:0]             rank;
    logic [PW-1:0]             prod;

    assign in_range = (32'(in_channel) < 32'(CHANNELS));
    assign row      = CW'(ch_reg);
    assign fill_cur = fill_reg[row];
    assign ptr_cur  = ptr_reg[row];
    assign fill_wr  = (fill_cur == FW'(WINDOW)) ? fill_cur : fill_cur + 1'b1;
    assign ptr_wr   = (ptr_cur == IW'(WINDOW - 1)) ? '0 : ptr_cur + 1'b1;
    assign wr_addr  = AW'({row, ptr_cur});
    assign rd_addr  = AW'({row, idx[IW-1:0]});

    // slots beyond the fill count were not written since reset and read as zero
    assign ins_val  = (FW'(rd_idx_reg) < cur_fill_reg) ? mem_q_reg : '0;

    // floor(sum / KEEP) by reciprocal multiplication, exact for any SUM_W-bit sum
    assign prod     = PW'(acc_reg) * PW'(RECIP);

    always_comb
    begin
        sort_next[0] = (sort_reg[0] <= ins_val) ? sort_reg[0] : ins_val;
        for (int i = 1; i < WINDOW; i++)
        begin
            if (sort_reg[i] <= ins_val)
            begin
                sort_next[i] = sort_reg[i];
            end
            else if (sort_reg[i-1] <= ins_val)
            begin
                sort_next[i] = ins_val;
            end
            else
            begin
                sort_next[i] = sort_reg[i-1];
            end
        end
    end

    always_comb
    begin
        int r;
        r = BASE + int'(idx);
        if (r < 0)
        begin
            r = 0;
        end
        if (r > WINDOW - 1)
        begin
            r = WINDOW - 1;
        end
        rank = IW'(r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                fill_reg[i] <= '0;
                ptr_reg[i]  <= '0;
            end
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.write)
            begin
                fill_reg[row] <= fill_wr;
                ptr_reg[row]  <= ptr_wr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[wr_addr] <= smp_reg;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg  <= in_channel;
            smp_reg <= in_distance;
        end
        if (cmd.write)
        begin
            cur_fill_reg <= fill_wr;
        end
        if (cmd.rd_en)
        begin
            rd_idx_reg <= idx[IW-1:0];
        end
        if (cmd.sort_init)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                sort_reg[i] <= '1;
            end
        end
        else if (rd_valid_reg)
        begin
            sort_reg <= sort_next;
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + SUM_W'(sort_reg[rank]);
        end
        if (cmd.load)
        begin
            q_reg <= '0;
        end
        else if (cmd.div_en)
        begin
            q_reg <= prod[SH +: QW];
        end
        if (cmd.out_load)
        begin
            out_ch_reg   <= ch_reg;
            out_dist_reg <= DW'(q_reg);
        end
    end

    assign out_channel  = out_ch_reg;
    assign out_distance = out_dist_reg;

endmodule

`default_nettype wire

[hdl/wtmf_checker.sv]
// Port-level assertions for the filter top level, with the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module wtmf_checker #(
    parameter int CHANNELS = wtmf_pkg::CHANNELS_DEF
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic [15:0]               s_tdata,
    input wire logic [wtmf_pkg::CH_W-1:0] s_tuser,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [15:0]               m_tdata,
    input wire logic [wtmf_pkg::CH_W-1:0] m_tuser
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // no result can appear in the cycle after an item is taken
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // a channel without a window yields zero
    a_bad_ch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (32'(m_tuser) >= 32'(CHANNELS)) |-> m_tdata == 16'd0)
        else $error("nonzero result for unused channel");

    a_rst: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind window_trimmed_mean_filter_top wtmf_checker #(
    .CHANNELS (CHANNELS)
) u_wtmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
